[hw/rtl/lew_pkg.sv]
`default_nettype none

package lew_pkg;

   localparam int DEF_MAX_HALF_RANGE = 1024;

   localparam int LOG_HALF_RANGE_W = 4;
   localparam logic [LOG_HALF_RANGE_W-1:0] LOG_HALF_RANGE_RESET = 4'd10;

   localparam int JUMP_W = 12;
   localparam int POSITION_W = 13;
   localparam int PATH_LEN_W = 12;

   localparam logic ACTION_JUMP = 1'b0;
   localparam logic ACTION_RESTART = 1'b1;

   typedef struct packed {
      logic action;
      logic [JUMP_W-1:0] jump_length;
      logic jump_negative;
   } req_type;

   typedef struct packed {
      logic signed [POSITION_W-1:0] position;
      logic [PATH_LEN_W-1:0] path_length;
      logic loop_closed;
      logic escaped;
   } rsp_type;

   typedef struct packed {
      logic map_wr;
      logic map_rd;
      logic map_wdata;
      logic stack_wr;
      logic stack_rd;
   } mem_ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STEP,
      ST_LOOKUP,
      ST_POP_READ,
      ST_POP_TEST,
      ST_ESCAPE,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

[hw/rtl/lew_path_mem.sv]
`default_nettype none

module lew_path_mem #(
   parameter int MAX_HALF_RANGE = lew_pkg::DEF_MAX_HALF_RANGE,
   localparam int DEPTH = 2 * MAX_HALF_RANGE,
   localparam int ADDR_W = $clog2(DEPTH),
   localparam int POS_W = $clog2(MAX_HALF_RANGE) + 3
) (
   input  wire logic clock,
   input  wire lew_pkg::mem_ctl_type ctl,
   input  wire logic [ADDR_W-1:0] map_addr,
   input  wire logic [ADDR_W-1:0] stack_addr,
   input  wire logic signed [POS_W-1:0] stack_wdata,
   output logic map_rdata,
   output logic signed [POS_W-1:0] stack_rdata
);
   import lew_pkg::*;

   logic map_mem [DEPTH];
   logic signed [POS_W-1:0] stack_mem [DEPTH];
   logic map_rdata_ff;
   logic signed [POS_W-1:0] stack_rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.map_wr) begin
         map_mem[map_addr] <= ctl.map_wdata;
      end
      if (ctl.map_rd) begin
         map_rdata_ff <= map_mem[map_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.stack_wr) begin
         stack_mem[stack_addr] <= stack_wdata;
      end
      if (ctl.stack_rd) begin
         stack_rdata_ff <= stack_mem[stack_addr];
      end
   end

   assign map_rdata = map_rdata_ff;
   assign stack_rdata = stack_rdata_ff;

endmodule

`default_nettype wire

[hw/rtl/loop_erased_walk_engine.sv]
// A jump that lands off the path is looked up in the visited map, appended to the path if there
// is room and checked for escape; a loop-closing jump erases path entries back to the position
// it landed on, and a restart erases every entry above the origin; a jump after escape goes
// straight to the result. One item at a time; the next item is taken once the last result is
// registered. After reset a clearing pass runs through all 2*MAX_HALF_RANGE entries of the
// visited map before the first item is taken; configuration writes are taken at any time.
`default_nettype none

module loop_erased_walk_engine #(
   parameter int MAX_HALF_RANGE = lew_pkg::DEF_MAX_HALF_RANGE
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire lew_pkg::req_type req_data,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output lew_pkg::rsp_type rsp_data,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [lew_pkg::LOG_HALF_RANGE_W-1:0] csr_data
);
   import lew_pkg::*;

   localparam int DEPTH = 2 * MAX_HALF_RANGE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = $clog2(MAX_HALF_RANGE) + 3;
   localparam int HALF_W = $clog2(MAX_HALF_RANGE + 1);
   localparam int SHIFT_W = 2 ** LOG_HALF_RANGE_W + 1;
   localparam int CMP_W = (HALF_W + 1 > JUMP_W) ? HALF_W + 1 : JUMP_W;
   localparam logic signed [POS_W:0] IDX_OFFSET = (POS_W + 1)'(MAX_HALF_RANGE);
   localparam logic signed [POS_W:0] IDX_LIMIT = (POS_W + 1)'(DEPTH);

   state_type state_ff, state_in;
   logic [LOG_HALF_RANGE_W-1:0] log_half_range_ff;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic restart_ff, restart_in;
   logic [JUMP_W-1:0] len_ff, len_in;
   logic neg_ff, neg_in;
   logic signed [POS_W-1:0] next_ff, next_in;
   logic [ADDR_W-1:0] map_idx_ff, map_idx_in;
   logic in_map_ff, in_map_in;
   logic loop_ff, loop_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic signed [POS_W-1:0] pos_ff, pos_in;
   logic done_ff, done_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   mem_ctl_type mem_ctl;
   logic [ADDR_W-1:0] map_addr;
   logic [ADDR_W-1:0] stack_addr;
   logic signed [POS_W-1:0] stack_wdata;
   logic map_rdata;
   logic signed [POS_W-1:0] stack_rdata;

   logic [SHIFT_W-1:0] half_shift;
   logic [HALF_W-1:0] half_range;
   logic [CMP_W-1:0] twice_half;
   logic signed [POS_W-1:0] len_ext;
   logic signed [POS_W-1:0] next_sum;
   logic signed [POS_W:0] step_idx;
   logic step_in_map;
   logic signed [POS_W:0] top_idx;
   logic top_in_map;
   logic [POS_W-1:0] next_mag;
   logic [CNT_W-1:0] count_dec;

   lew_path_mem #(
      .MAX_HALF_RANGE(MAX_HALF_RANGE)
   ) u_path_mem (
      .clock(clock),
      .ctl(mem_ctl),
      .map_addr(map_addr),
      .stack_addr(stack_addr),
      .stack_wdata(stack_wdata),
      .map_rdata(map_rdata),
      .stack_rdata(stack_rdata)
   );

   always_comb begin
      half_shift = SHIFT_W'(1) << log_half_range_ff;
      if (half_shift > SHIFT_W'(MAX_HALF_RANGE)) begin
         half_range = HALF_W'(MAX_HALF_RANGE);
      end else begin
         half_range = HALF_W'(half_shift);
      end
      twice_half = CMP_W'({half_range, 1'b0});

      len_ext = POS_W'(len_ff);
      next_sum = neg_ff ? pos_ff - len_ext : pos_ff + len_ext;
      step_idx = {next_sum[POS_W-1], next_sum} + IDX_OFFSET;
      step_in_map = !step_idx[POS_W] && (step_idx != '0) && (step_idx < IDX_LIMIT);
      top_idx = {stack_rdata[POS_W-1], stack_rdata} + IDX_OFFSET;
      top_in_map = !top_idx[POS_W] && (top_idx != '0) && (top_idx < IDX_LIMIT);
      next_mag = next_ff[POS_W-1] ? POS_W'(-next_ff) : POS_W'(next_ff);
      count_dec = count_ff - CNT_W'(1);
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         log_half_range_ff <= LOG_HALF_RANGE_RESET;
         clr_ff <= '0;
         count_ff <= CNT_W'(1);
         pos_ff <= '0;
         done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            log_half_range_ff <= csr_data;
         end
         clr_ff <= clr_in;
         count_ff <= count_in;
         pos_ff <= pos_in;
         done_ff <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      restart_ff <= restart_in;
      len_ff <= len_in;
      neg_ff <= neg_in;
      next_ff <= next_in;
      map_idx_ff <= map_idx_in;
      in_map_ff <= in_map_in;
      loop_ff <= loop_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      restart_in = restart_ff;
      len_in = len_ff;
      neg_in = neg_ff;
      next_in = next_ff;
      map_idx_in = map_idx_ff;
      in_map_in = in_map_ff;
      loop_in = loop_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      done_in = done_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_ctl = '0;
      map_addr = map_idx_ff;
      stack_addr = '0;
      stack_wdata = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_ctl.map_wr = 1'b1;
            mem_ctl.map_wdata = (clr_ff == ADDR_W'(MAX_HALF_RANGE));
            map_addr = clr_ff;
            mem_ctl.stack_wr = (clr_ff == '0);
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               restart_in = (req_data.action == ACTION_RESTART);
               loop_in = 1'b0;
               neg_in = req_data.jump_negative;
               if (CMP_W'(req_data.jump_length) > twice_half) begin
                  len_in = JUMP_W'(twice_half);
               end else begin
                  len_in = req_data.jump_length;
               end
               if (req_data.action == ACTION_RESTART) begin
                  state_in = ST_POP_READ;
               end else if (done_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            next_in = next_sum;
            in_map_in = step_in_map;
            map_idx_in = step_idx[ADDR_W-1:0];
            map_addr = step_idx[ADDR_W-1:0];
            mem_ctl.map_rd = 1'b1;
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (in_map_ff && map_rdata) begin
               loop_in = 1'b1;
               state_in = ST_POP_READ;
            end else begin
               if (count_ff < CNT_W'(DEPTH)) begin
                  mem_ctl.stack_wr = 1'b1;
                  stack_addr = count_ff[ADDR_W-1:0];
                  stack_wdata = next_ff;
                  mem_ctl.map_wr = in_map_ff;
                  mem_ctl.map_wdata = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = ST_ESCAPE;
            end
         end
         ST_POP_READ: begin
            if (count_ff > CNT_W'(1)) begin
               mem_ctl.stack_rd = 1'b1;
               stack_addr = count_dec[ADDR_W-1:0];
               state_in = ST_POP_TEST;
            end else if (restart_ff) begin
               pos_in = '0;
               done_in = 1'b0;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_ESCAPE;
            end
         end
         ST_POP_TEST: begin
            if (!restart_ff && (stack_rdata == next_ff)) begin
               state_in = ST_ESCAPE;
            end else begin
               mem_ctl.map_wr = top_in_map;
               mem_ctl.map_wdata = 1'b0;
               map_addr = top_idx[ADDR_W-1:0];
               count_in = count_dec;
               state_in = ST_POP_READ;
            end
         end
         ST_ESCAPE: begin
            pos_in = next_ff;
            if (next_mag >= POS_W'(half_range)) begin
               done_in = 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.position = POSITION_W'(pos_ff);
               rsp_in.path_length = PATH_LEN_W'(count_ff);
               rsp_in.loop_closed = loop_ff;
               rsp_in.escaped = done_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   // The origin is never popped, so the path always holds at least one entry.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0)
      else $error("path length fell to zero");

   // A restart result always reports the walker back at the origin.
   a_restart_origin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && restart_ff) |-> (pos_ff == '0 && count_ff == CNT_W'(1)
         && !done_ff))
      else $error("restart did not return the walker to the origin");

   // Every erase step removes exactly one entry.
   a_pop_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP_TEST && state_in == ST_POP_READ) |=>
         (count_ff == $past(count_dec)))
      else $error("erase step did not remove exactly one entry");

   // A new result is only loaded from the finishing state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("result appeared outside the finishing state");
`endif

endmodule

`default_nettype wire
